@@ rtl/core/hsbq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbq_pkg
// Shared types, codes and helper functions of the heightmap store with
// bilinear height query.
// ----------------------------------------------------------------------------
package hsbq_pkg;

  // Grid geometry and store size.
  localparam int MaxResolution = 256;
  localparam int CellBits      = $clog2(MaxResolution);
  localparam int StoreDepth    = MaxResolution * MaxResolution;
  localparam int AddrBits      = 2 * CellBits;
  localparam int ResBits       = CellBits + 1;

  // Arithmetic widths.
  localparam int NumBits = 49;   // dividend of the shared divider
  localparam int CntBits = 6;    // counts the divider steps

  typedef logic [1:0]          cmd_t;
  typedef logic [3:0]          reg_idx_t;
  typedef logic [ResBits-1:0]  res_t;
  typedef logic [CellBits-1:0] cell_t;
  typedef logic [AddrBits-1:0] addr_t;

  // Command codes.
  localparam cmd_t CMD_QUERY  = 2'd0;
  localparam cmd_t CMD_SET    = 2'd1;
  localparam cmd_t CMD_MODIFY = 2'd2;
  localparam cmd_t CMD_LOAD   = 2'd3;

  // Configuration register indexes.
  localparam reg_idx_t REG_GRID_RES   = 4'd0;
  localparam reg_idx_t REG_ORIGIN_X   = 4'd1;
  localparam reg_idx_t REG_ORIGIN_Y   = 4'd2;
  localparam reg_idx_t REG_ORIGIN_Z   = 4'd3;
  localparam reg_idx_t REG_INV_CELL_W = 4'd4;
  localparam reg_idx_t REG_INV_CELL_D = 4'd5;
  localparam reg_idx_t REG_HEIGHT_SCL = 4'd6;
  localparam reg_idx_t REG_SCALE_EN   = 4'd7;

  // Clamp an unsigned Q32.32 grid coordinate to the limit cell and split it
  // into the cell index and the top 16 fraction bits.
  function automatic logic [CellBits+15:0] grid_split(input logic [63:0] h,
                                                      input cell_t lim);
    logic over;
    over = (h[63:32] > {{(32-CellBits){1'b0}}, lim}) ||
           ((h[63:32] == {{(32-CellBits){1'b0}}, lim}) && (h[31:0] != 32'd0));
    if (over) begin
      grid_split = {lim, 16'd0};
    end else begin
      grid_split = {h[32+CellBits-1:32], h[31:16]};
    end
  endfunction

  // Saturate a 35-bit signed sum to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ rtl/core/heightmap_store_bilinear_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_store_bilinear_query
// Square height grid with load, set and modify writes and a bilinear query.
// ----------------------------------------------------------------------------
// Usage:
// - Items enter on the in_ channel (valid/ready) and carry a command, a world
//   position, a grid cell and a value. Every item gives exactly one result on
//   the out_ channel (valid/ready).
// - Configuration registers are written through the cfg_ channel, which is
//   always ready. Write them only while no item is in flight.
// - One item is worked on at a time; in_ready is high only while idle.
//   Load and out-of-range writes skip the arithmetic; set above the Y origin
//   and modify run the 49-step shared divider, and a query runs both it and
//   the single multiplier (one product per cycle, used by every multiply of
//   the query); the four corner heights come one per cycle from the single
//   store read port.
// - A finished result sits in the output register; the block takes the next
//   item while it waits, and stalls only when a second result is ready
//   before the first one is taken.
// - After reset the block clears the whole store, one entry per cycle;
//   in_ready stays low during that pass.
// ----------------------------------------------------------------------------
module heightmap_store_bilinear_query (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hsbq_pkg::cmd_t         in_command,
  input  logic signed [31:0]     in_world_x,
  input  logic signed [31:0]     in_world_z,
  input  hsbq_pkg::res_t         in_grid_x,
  input  hsbq_pkg::res_t         in_grid_z,
  input  logic signed [31:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     out_world_height,
  output logic [15:0]            out_norm_height,
  output logic                   out_done_res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  hsbq_pkg::reg_idx_t     cfg_index,
  input  logic [31:0]            cfg_data
);
  import hsbq_pkg::*;

  // Sequencer codes.
  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_DEC   = 5'd2;
  localparam logic [4:0] ST_QMZ   = 5'd3;
  localparam logic [4:0] ST_QCZ   = 5'd4;
  localparam logic [4:0] ST_RD00  = 5'd5;
  localparam logic [4:0] ST_RD10  = 5'd6;
  localparam logic [4:0] ST_RD01  = 5'd7;
  localparam logic [4:0] ST_RD11  = 5'd8;
  localparam logic [4:0] ST_RDL   = 5'd9;
  localparam logic [4:0] ST_M0    = 5'd10;
  localparam logic [4:0] ST_M1    = 5'd11;
  localparam logic [4:0] ST_M2    = 5'd12;
  localparam logic [4:0] ST_M3    = 5'd13;
  localparam logic [4:0] ST_M4    = 5'd14;
  localparam logic [4:0] ST_M5    = 5'd15;
  localparam logic [4:0] ST_M6    = 5'd16;
  localparam logic [4:0] ST_NORM  = 5'd17;
  localparam logic [4:0] ST_SCL   = 5'd18;
  localparam logic [4:0] ST_DIVLD = 5'd19;
  localparam logic [4:0] ST_DIV   = 5'd20;
  localparam logic [4:0] ST_POST  = 5'd21;
  localparam logic [4:0] ST_WR    = 5'd22;
  localparam logic [4:0] ST_FIN   = 5'd23;

  localparam logic [CntBits-1:0] DivLast = CntBits'(NumBits - 1);

  // Configuration registers.
  res_t               grid_res_r;
  logic signed [31:0] origin_x_r;
  logic signed [31:0] origin_y_r;
  logic signed [31:0] origin_z_r;
  logic [31:0]        inv_w_r;
  logic [31:0]        inv_d_r;
  logic [31:0]        hscale_r;
  logic               scale_en_r;

  // Control state.
  logic [4:0]          state_r, state_nxt;
  addr_t               clr_addr_r;
  logic [CntBits-1:0]  div_cnt_r;
  logic                out_valid_r;

  // Captured item.
  cmd_t               cmd_r;
  logic signed [31:0] wx_r, wz_r, val_r;
  res_t               gx_r, gz_r;

  // Datapath registers.
  cell_t              x0_r, z0_r;
  logic [15:0]        fx_r, fz_r;
  logic [15:0]        h00_r, h10_r, h01_r, h11_r, cell_val_r;
  logic [63:0]        prod_r, acc_r;
  logic [31:0]        r0_r, r1_r;
  logic [15:0]        norm_r, nv_r;
  logic [NumBits-1:0] num_r;
  logic [31:0]        den_r, rem_r;
  logic [31:0]        res_world_r;
  logic [15:0]        res_norm_r;
  logic               res_done_r;
  logic [31:0]        out_world_r;
  logic [15:0]        out_norm_r;
  logic               out_done_r;

  // Store.
  logic [15:0] mem [StoreDepth];
  logic [15:0] rd_q_r;
  addr_t       rd_addr;
  logic        mem_we;
  addr_t       mem_waddr;
  logic [15:0] mem_wdata;

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;

  // Derived configuration values.
  res_t        eff_res;
  cell_t       lim;
  logic [31:0] hs_eff, sc_eff;
  logic [31:0] off_eff;

  // Item decode helpers.
  logic signed [32:0] lx, lz, dv;
  logic [31:0]        lx_u, lz_u, mag;
  logic               lx_pos, lz_pos, out_of_range;
  logic [16:0]        wfx, wfz;
  logic [7:0]         load_byte;
  logic [CellBits+15:0] split_q;

  // Divider step.
  logic [32:0]        div_rsh;
  logic               div_ge;

  // Post-division values.
  logic [16:0]        q17;
  logic [17:0]        mod_sum;
  logic signed [34:0] world_sum;
  logic [15:0]        mod_nv;
  logic               fin_load;

  // Effective configuration.
  always_comb begin
    if (grid_res_r < res_t'(2)) begin
      eff_res = res_t'(2);
    end else if (grid_res_r > res_t'(MaxResolution)) begin
      eff_res = res_t'(MaxResolution);
    end else begin
      eff_res = grid_res_r;
    end
  end
  assign lim     = CellBits'(eff_res - res_t'(2));
  assign hs_eff  = (hscale_r == 32'd0) ? 32'd1 : hscale_r;
  assign sc_eff  = scale_en_r ? hs_eff : 32'd65536;
  assign off_eff = scale_en_r ? origin_y_r : 32'd0;

  // Offsets from the terrain origin and the magnitudes fed to the multiplier.
  assign lx     = {wx_r[31], wx_r} - {origin_x_r[31], origin_x_r};
  assign lz     = {wz_r[31], wz_r} - {origin_z_r[31], origin_z_r};
  assign lx_pos = !lx[32] && (lx != 33'sd0);
  assign lz_pos = !lz[32] && (lz != 33'sd0);
  assign lx_u   = lx_pos ? lx[31:0] : 32'd0;
  assign lz_u   = lz_pos ? lz[31:0] : 32'd0;
  assign dv     = {val_r[31], val_r} - {origin_y_r[31], origin_y_r};
  assign mag    = val_r[31] ? (~val_r + 32'd1) : val_r;
  assign wfx    = 17'h10000 - {1'b0, fx_r};
  assign wfz    = 17'h10000 - {1'b0, fz_r};
  assign out_of_range = (gx_r >= eff_res) || (gz_r >= eff_res);
  assign split_q = grid_split(prod_r, lim);

  // Raw byte for load, saturated to [0, 255].
  always_comb begin
    if (val_r[31]) begin
      load_byte = 8'd0;
    end else if (val_r > 32'sd255) begin
      load_byte = 8'hFF;
    end else begin
      load_byte = val_r[7:0];
    end
  end

  // One restoring division step.
  assign div_rsh = {rem_r, num_r[NumBits-1]};
  assign div_ge  = div_rsh >= {1'b0, den_r};

  // Rounding and clamping after division.
  assign q17 = (|num_r[NumBits-1:16]) ? 17'h10000 : {1'b0, num_r[15:0]};
  always_comb begin
    if (val_r[31]) begin
      mod_sum = {2'b00, cell_val_r} - {1'b0, q17};
      mod_nv  = mod_sum[17] ? 16'd0 : mod_sum[15:0];
    end else begin
      mod_sum = {2'b00, cell_val_r} + {1'b0, q17};
      mod_nv  = (mod_sum > 18'd65535) ? 16'hFFFF : mod_sum[15:0];
    end
  end
  assign world_sum = $signed({2'b00, num_r[32:0]}) +
                     $signed({{3{off_eff[31]}}, off_eff});

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      ST_DEC: begin
        if (cmd_r == CMD_QUERY) begin
          mul_a = lx_u;
          mul_b = inv_w_r;
        end else if (cmd_r == CMD_SET) begin
          mul_a = dv[31:0];
          mul_b = 32'd65535;
        end else begin
          mul_a = mag;
          mul_b = 32'd65535;
        end
      end
      ST_QMZ: begin
        mul_a = lz_u;
        mul_b = inv_d_r;
      end
      ST_M0: begin
        mul_a = {16'd0, h00_r};
        mul_b = {15'd0, wfx};
      end
      ST_M1: begin
        mul_a = {16'd0, h10_r};
        mul_b = {16'd0, fx_r};
      end
      ST_M2: begin
        mul_a = {16'd0, h01_r};
        mul_b = {15'd0, wfx};
      end
      ST_M3: begin
        mul_a = {16'd0, h11_r};
        mul_b = {16'd0, fx_r};
      end
      ST_M4: begin
        mul_a = r0_r;
        mul_b = {15'd0, wfz};
      end
      ST_M5: begin
        mul_a = r1_r;
        mul_b = {16'd0, fz_r};
      end
      ST_SCL: begin
        mul_a = {16'd0, norm_r};
        mul_b = sc_eff;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Store read address per step.
  always_comb begin
    unique case (state_r)
      ST_RD10: rd_addr = {z0_r, x0_r + cell_t'(1)};
      ST_RD01: rd_addr = {z0_r + cell_t'(1), x0_r};
      ST_RD11: rd_addr = {z0_r + cell_t'(1), x0_r + cell_t'(1)};
      ST_DEC:  rd_addr = {gz_r[CellBits-1:0], gx_r[CellBits-1:0]};
      default: rd_addr = {z0_r, x0_r};
    endcase
  end

  // Store write port: clearing pass or the final write of an item.
  assign mem_we    = (state_r == ST_CLEAR) || (state_r == ST_WR);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r
                                           : {gz_r[CellBits-1:0], gx_r[CellBits-1:0]};
  assign mem_wdata = (state_r == ST_CLEAR) ? 16'd0 : nv_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Result handoff to the output register.
  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == addr_t'(StoreDepth - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_DEC;
      ST_DEC: begin
        if (cmd_r == CMD_QUERY) begin
          state_nxt = ST_QMZ;
        end else if (out_of_range) begin
          state_nxt = ST_FIN;
        end else if (cmd_r == CMD_LOAD) begin
          state_nxt = ST_WR;
        end else if ((cmd_r == CMD_SET) && (dv[32] || (dv == 33'sd0))) begin
          state_nxt = ST_WR;
        end else begin
          state_nxt = ST_DIVLD;
        end
      end
      ST_QMZ:   state_nxt = ST_QCZ;
      ST_QCZ:   state_nxt = ST_RD00;
      ST_RD00:  state_nxt = ST_RD10;
      ST_RD10:  state_nxt = ST_RD01;
      ST_RD01:  state_nxt = ST_RD11;
      ST_RD11:  state_nxt = ST_RDL;
      ST_RDL:   state_nxt = ST_M0;
      ST_M0:    state_nxt = ST_M1;
      ST_M1:    state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_M4;
      ST_M4:    state_nxt = ST_M5;
      ST_M5:    state_nxt = ST_M6;
      ST_M6:    state_nxt = ST_NORM;
      ST_NORM:  state_nxt = ST_SCL;
      ST_SCL:   state_nxt = ST_DIVLD;
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV:   if (div_cnt_r == DivLast) state_nxt = ST_POST;
      ST_POST:  state_nxt = (cmd_r == CMD_QUERY) ? ST_FIN : ST_WR;
      ST_WR:    state_nxt = ST_FIN;
      ST_FIN:   if (fin_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      grid_res_r  <= res_t'(MaxResolution);
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      origin_z_r  <= '0;
      inv_w_r     <= 32'd65536;
      inv_d_r     <= 32'd65536;
      hscale_r    <= 32'd65536;
      scale_en_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + addr_t'(1);
      end
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + CntBits'(1);
      end else begin
        div_cnt_r <= '0;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_GRID_RES:   grid_res_r <= cfg_data[ResBits-1:0];
          REG_ORIGIN_X:   origin_x_r <= cfg_data;
          REG_ORIGIN_Y:   origin_y_r <= cfg_data;
          REG_ORIGIN_Z:   origin_z_r <= cfg_data;
          REG_INV_CELL_W: inv_w_r    <= cfg_data;
          REG_INV_CELL_D: inv_d_r    <= cfg_data;
          REG_HEIGHT_SCL: hscale_r   <= cfg_data;
          REG_SCALE_EN:   scale_en_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, loaded by the sequencer step.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if ((state_r == ST_IDLE) && in_valid) begin
      cmd_r <= in_command;
      wx_r  <= in_world_x;
      wz_r  <= in_world_z;
      gx_r  <= in_grid_x;
      gz_r  <= in_grid_z;
      val_r <= in_value;
    end
    case (state_r)
      ST_DEC: begin
        if ((cmd_r != CMD_QUERY) && out_of_range) begin
          res_world_r <= 32'd0;
          res_norm_r  <= 16'd0;
          res_done_r  <= 1'b0;
        end
        if (cmd_r == CMD_LOAD) begin
          nv_r <= {load_byte, load_byte};
        end else begin
          nv_r <= 16'd0;
        end
      end
      ST_QMZ:  {x0_r, fx_r} <= split_q;
      ST_QCZ:  {z0_r, fz_r} <= split_q;
      ST_RD10: h00_r <= rd_q_r;
      ST_RD01: h10_r <= rd_q_r;
      ST_RD11: h01_r <= rd_q_r;
      ST_RDL:  h11_r <= rd_q_r;
      ST_M1:   acc_r <= prod_r;
      ST_M2:   r0_r  <= 32'(acc_r + prod_r);
      ST_M3:   acc_r <= prod_r;
      ST_M4:   r1_r  <= 32'(acc_r + prod_r);
      ST_M5:   acc_r <= prod_r;
      ST_M6:   acc_r <= acc_r + prod_r;
      ST_NORM: begin
        // Round the Q.32 sum half up to 16 bits.
        if (|acc_r[63:48] || (acc_r[47:31] == 17'h1FFFF)) begin
          norm_r <= 16'hFFFF;
        end else begin
          norm_r <= 16'(acc_r[47:32] + {15'd0, acc_r[31]});
        end
      end
      ST_DIVLD: begin
        rem_r      <= 32'd0;
        cell_val_r <= rd_q_r;
        if (cmd_r == CMD_QUERY) begin
          num_r <= prod_r[NumBits-1:0] + NumBits'(32767);
          den_r <= 32'd65535;
        end else begin
          num_r <= prod_r[NumBits-1:0] + NumBits'(hs_eff >> 1);
          den_r <= hs_eff;
        end
      end
      ST_DIV: begin
        // Shift the next dividend bit in and the quotient bit out.
        num_r <= {num_r[NumBits-2:0], div_ge};
        rem_r <= div_ge ? 32'(div_rsh - {1'b0, den_r}) : div_rsh[31:0];
      end
      ST_POST: begin
        if (cmd_r == CMD_QUERY) begin
          res_world_r <= sat32(world_sum);
          res_norm_r  <= norm_r;
          res_done_r  <= 1'b1;
        end else if (cmd_r == CMD_SET) begin
          nv_r <= (|num_r[NumBits-1:16]) ? 16'hFFFF : num_r[15:0];
        end else begin
          nv_r <= mod_nv;
        end
      end
      ST_WR: begin
        res_world_r <= 32'd0;
        res_norm_r  <= nv_r;
        res_done_r  <= 1'b1;
      end
      default: ;
    endcase
    if (fin_load) begin
      out_world_r <= res_world_r;
      out_norm_r  <= res_norm_r;
      out_done_r  <= res_done_r;
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_world_height = out_world_r;
  assign out_norm_height  = out_norm_r;
  assign out_done_res     = out_done_r;

  // No item is taken during the clearing pass.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during store clear");

  // A rejected write reports zero height.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_norm_height == 16'd0) &&
                                     (out_world_height == 32'sd0))
    else $error("rejected item carries a height");

  // The store is written only by the clear pass or the final write step.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_CLEAR) || (state_r == ST_WR)))
    else $error("unexpected store write");

  // The divider step count never runs past its last step.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= DivLast))
    else $error("divider step count overrun");

  // A result is loaded only when the output register is free or being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_norm_r))
    else $error("pending result overwritten");

endmodule
